[sv/adsr_pkg.sv]
// Shared constants and types for the linear ADSR envelope generator.
// Stage codes, operation codes and configuration register map.
// No dependencies.
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int DEF_LEVEL_FRAC_BITS = 16;

    typedef logic [2:0] stage_t;
    typedef logic [1:0] op_t;
    typedef logic [1:0] reg_idx_t;

    localparam stage_t ST_IDLE    = 3'd0;
    localparam stage_t ST_ATTACK  = 3'd1;
    localparam stage_t ST_DECAY   = 3'd2;
    localparam stage_t ST_SUSTAIN = 3'd3;
    localparam stage_t ST_RELEASE = 3'd4;

    localparam op_t OP_TICK    = 2'd0;
    localparam op_t OP_TRIGGER = 2'd1;
    localparam op_t OP_RELEASE = 2'd2;

    // APB register map, one 32-bit register per word
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam reg_idx_t REG_ATTACK_STEP   = 2'd0;
    localparam reg_idx_t REG_DECAY_STEP    = 2'd1;
    localparam reg_idx_t REG_SUSTAIN_LEVEL = 2'd2;

endpackage

[sv/adsr_cfg_regs.sv]
// APB configuration registers: attack step, decay step, sustain level.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

module adsr_cfg_regs
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    output logic [LEVEL_FRAC_BITS:0]   attack_step,
    output logic [LEVEL_FRAC_BITS:0]   decay_step,
    output logic [LEVEL_FRAC_BITS:0]   sustain_level
);

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    logic [LW-1:0] attack_reg;
    logic [LW-1:0] decay_reg;
    logic [LW-1:0] sustain_reg;
    logic          wr_en;
    reg_idx_t      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= FULL;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ATTACK_STEP:   attack_reg  <= pwdata[LW-1:0];
                REG_DECAY_STEP:    decay_reg   <= pwdata[LW-1:0];
                REG_SUSTAIN_LEVEL: sustain_reg <= pwdata[LW-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ATTACK_STEP:   prdata = APB_DATA_W'(attack_reg);
            REG_DECAY_STEP:    prdata = APB_DATA_W'(decay_reg);
            REG_SUSTAIN_LEVEL: prdata = APB_DATA_W'(sustain_reg);
            default:           prdata = '0;
        endcase
    end

    assign attack_step   = attack_reg;
    assign decay_step    = decay_reg;
    assign sustain_level = sustain_reg;

endmodule

[sv/adsr_step.sv]
// Next-state logic of the envelope: one add or subtract and compare per word.
// Purely combinational. Depends on adsr_pkg.
`timescale 1ns / 1ps

module adsr_step
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
)
(
    input  op_t                        op,
    input  logic [LEVEL_FRAC_BITS:0]   rel_in,
    input  logic [LEVEL_FRAC_BITS:0]   cur_level,
    input  stage_t                     cur_stage,
    input  logic [LEVEL_FRAC_BITS:0]   cur_rel,
    input  logic [LEVEL_FRAC_BITS:0]   attack_step,
    input  logic [LEVEL_FRAC_BITS:0]   decay_step,
    input  logic [LEVEL_FRAC_BITS:0]   sustain_level,
    output logic [LEVEL_FRAC_BITS:0]   nxt_level,
    output stage_t                     nxt_stage,
    output logic [LEVEL_FRAC_BITS:0]   nxt_rel
);

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    function automatic logic [LW-1:0] sat_full(input logic [LW-1:0] v);
        return (v > FULL) ? FULL : v;
    endfunction

    logic [LW-1:0] sus;
    logic [LW-1:0] att;
    logic [LW-1:0] dec;
    logic [LW:0]   att_sum;
    logic [LW-1:0] dec_lvl;
    logic [LW-1:0] rel_lvl;

    always_comb
    begin
        sus     = sat_full(sustain_level);
        att     = sat_full(attack_step);
        dec     = sat_full(decay_step);
        att_sum = {1'b0, cur_level} + {1'b0, att};
        dec_lvl = (cur_level > dec) ? cur_level - dec : '0;
        rel_lvl = (cur_level > cur_rel) ? cur_level - cur_rel : '0;

        nxt_level = cur_level;
        nxt_stage = cur_stage;
        nxt_rel   = cur_rel;

        case (op)
            OP_TICK:
            begin
                case (cur_stage)
                    ST_ATTACK:
                    begin
                        if (att_sum >= {1'b0, FULL})
                        begin
                            if (decay_step == '0)
                            begin
                                nxt_level = sus;
                                nxt_stage = ST_SUSTAIN;
                            end
                            else
                            begin
                                nxt_level = FULL;
                                nxt_stage = ST_DECAY;
                            end
                        end
                        else
                        begin
                            nxt_level = att_sum[LW-1:0];
                        end
                    end
                    ST_DECAY:
                    begin
                        if (dec_lvl <= sus)
                        begin
                            nxt_level = sus;
                            nxt_stage = ST_SUSTAIN;
                        end
                        else
                        begin
                            nxt_level = dec_lvl;
                        end
                    end
                    ST_SUSTAIN:
                    begin
                        nxt_level = sus;
                    end
                    ST_RELEASE:
                    begin
                        nxt_level = rel_lvl;
                        if (rel_lvl == '0)
                        begin
                            nxt_stage = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        nxt_level = '0;
                        nxt_stage = ST_IDLE;
                    end
                endcase
            end
            OP_TRIGGER:
            begin
                nxt_rel = '0;
                if (attack_step == '0)
                begin
                    if (decay_step == '0)
                    begin
                        nxt_level = sus;
                        nxt_stage = ST_SUSTAIN;
                    end
                    else
                    begin
                        nxt_level = FULL;
                        nxt_stage = ST_DECAY;
                    end
                end
                else
                begin
                    nxt_level = '0;
                    nxt_stage = ST_ATTACK;
                end
            end
            OP_RELEASE:
            begin
                // release while idle is ignored, stored step kept
                if (cur_stage != ST_IDLE)
                begin
                    nxt_rel   = sat_full(rel_in);
                    nxt_stage = ST_RELEASE;
                end
            end
            default:
            begin
                nxt_level = cur_level;
            end
        endcase
    end

endmodule

[sv/adsr_env_core.sv]
// Envelope pipeline: input register, envelope state, result register.
// Depends on adsr_pkg and adsr_step.
`timescale 1ns / 1ps

module adsr_env_core
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  op_t                        operation,
    input  logic [LEVEL_FRAC_BITS:0]   release_step,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [LEVEL_FRAC_BITS:0]   level,
    output stage_t                     stage,
    output logic                       idle,
    input  logic [LEVEL_FRAC_BITS:0]   attack_step,
    input  logic [LEVEL_FRAC_BITS:0]   decay_step,
    input  logic [LEVEL_FRAC_BITS:0]   sustain_level
);

    localparam int LW = LEVEL_FRAC_BITS + 1;

    logic          in_valid_reg;
    op_t           op_reg;
    logic [LW-1:0] rel_in_reg;

    logic [LW-1:0] env_level_reg;
    stage_t        env_stage_reg;
    logic [LW-1:0] rel_step_reg;

    logic [LW-1:0] env_level_next;
    stage_t        env_stage_next;
    logic [LW-1:0] rel_step_next;

    logic          out_valid_reg;
    logic [LW-1:0] level_reg;
    stage_t        stage_reg;

    logic          advance;

    // pipe moves unless a result is held by the sink; an empty input register still loads
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg     <= operation;
            rel_in_reg <= release_step;
        end
    end

    adsr_step #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_step (
        .op            (op_reg),
        .rel_in        (rel_in_reg),
        .cur_level     (env_level_reg),
        .cur_stage     (env_stage_reg),
        .cur_rel       (rel_step_reg),
        .attack_step   (attack_step),
        .decay_step    (decay_step),
        .sustain_level (sustain_level),
        .nxt_level     (env_level_next),
        .nxt_stage     (env_stage_next),
        .nxt_rel       (rel_step_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_level_reg <= '0;
            env_stage_reg <= ST_IDLE;
            rel_step_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                env_level_reg <= env_level_next;
                env_stage_reg <= env_stage_next;
                rel_step_reg  <= rel_step_next;
            end
        end
    end

    // result shows the level before the update and the stage after it
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            level_reg <= env_level_reg;
            stage_reg <= env_stage_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign stage     = stage_reg;
    assign idle      = (stage_reg == ST_IDLE);

endmodule

[sv/adsr_envelope_generator_top.sv]
// Linear ADSR envelope generator, unsigned fixed-point level, 1.0 = 2^LEVEL_FRAC_BITS.
// An accepted word passes the input register and then the result register.
// Throughput: one word per cycle unless the sink holds a result; the single add/subtract and compare stage sets it.
// Reset (rst_n, async, active low): pipe empty, level 0, stage idle, release step 0,
// attack and decay steps 0, sustain level full scale.
// Depends on adsr_pkg, adsr_cfg_regs, adsr_env_core.
`timescale 1ns / 1ps

module adsr_envelope_generator_top
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 operation,
    input  logic [LEVEL_FRAC_BITS:0]   release_step,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [LEVEL_FRAC_BITS:0]   level,
    output logic [2:0]                 stage,
    output logic                       idle
);

    logic [LEVEL_FRAC_BITS:0] attack_step;
    logic [LEVEL_FRAC_BITS:0] decay_step;
    logic [LEVEL_FRAC_BITS:0] sustain_level;

    adsr_cfg_regs #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .attack_step   (attack_step),
        .decay_step    (decay_step),
        .sustain_level (sustain_level)
    );

    adsr_env_core #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .release_step  (release_step),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .stage         (stage),
        .idle          (idle),
        .attack_step   (attack_step),
        .decay_step    (decay_step),
        .sustain_level (sustain_level)
    );

endmodule

[sv/adsr_checker.sv]
// Port-level checks on the envelope result channel, bound to the top level.
// Depends on adsr_pkg and adsr_envelope_generator_top.
`timescale 1ns / 1ps

module adsr_checker
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [LEVEL_FRAC_BITS:0]   level,
    input  logic [2:0]                 stage,
    input  logic                       idle
);

    localparam logic [LEVEL_FRAC_BITS:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(stage))
        else $error("result word changed while stalled");

    a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idle == (stage == ST_IDLE)))
        else $error("idle flag disagrees with stage");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level <= FULL)
        else $error("level above full scale");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stage <= ST_RELEASE)
        else $error("stage code out of range");

endmodule

bind adsr_envelope_generator_top adsr_checker #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_adsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .stage     (stage),
    .idle      (idle)
);
